### rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Types and constants shared by the length-prefix deframer modules.
// ----------------------------------------------------------------------------
package lpd_pkg;

   localparam int unsigned LEN_WIDTH   = 32;
   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned SHIFT_WIDTH = 24;

   // reset value of the maximum body length register
   localparam logic [LEN_WIDTH-1:0] MAX_BODY_RESET = 32'd65536;

   // header bytes gathered before the final length byte arrives
   localparam logic [1:0] HDR_LAST_INDEX = 2'd3;

   // result kind codes
   localparam logic KIND_BODY  = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_BODY    = 2'd1,
      PH_DISCARD = 2'd2
   } phase_type;

   typedef struct packed {
      logic                  kind;
      logic [BYTE_WIDTH-1:0] body_byte;
      logic                  frame_last;
      logic [LEN_WIDTH-1:0]  bad_length;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } step_type;

endpackage

### rtl/lpd_req_if.sv
// ----------------------------------------------------------------------------
// lpd_req_if
// Byte stream channel: one received byte and its chunk end flag per item.
// ----------------------------------------------------------------------------
interface lpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       chunk_end;

   modport source (output valid, output data_byte, output chunk_end, input ready);
   modport sink   (input valid, input data_byte, input chunk_end, output ready);
endinterface

### rtl/lpd_rsp_if.sv
// ----------------------------------------------------------------------------
// lpd_rsp_if
// Result channel: body bytes with frame end marker, or length errors.
// ----------------------------------------------------------------------------
interface lpd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  body_byte;
   logic        frame_last;
   logic [31:0] bad_length;

   modport source (output valid, output kind, output body_byte, output frame_last,
                   output bad_length, input ready);
   modport sink   (input valid, input kind, input body_byte, input frame_last,
                   input bad_length, output ready);
endinterface

### rtl/lpd_parser.sv
// ----------------------------------------------------------------------------
// lpd_parser
// Frame state machine: header assembly, body countdown, discard to chunk end.
// ----------------------------------------------------------------------------
module lpd_parser (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [lpd_pkg::BYTE_WIDTH-1:0]        data_byte,
   input  logic                                  chunk_end,
   input  logic [lpd_pkg::LEN_WIDTH-1:0]         max_body_length,
   output lpd_pkg::step_type                     step
);

   lpd_pkg::phase_type                   phase_ff, phase_in;
   logic [1:0]                           hdr_count_ff, hdr_count_in;
   logic [lpd_pkg::SHIFT_WIDTH-1:0]      hdr_shift_ff, hdr_shift_in;
   logic [lpd_pkg::LEN_WIDTH-1:0]        remaining_ff, remaining_in;
   logic [lpd_pkg::LEN_WIDTH-1:0]        length;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lpd_pkg::PH_HEADER;
         hdr_count_ff <= 2'd0;
         hdr_shift_ff <= '0;
         remaining_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         hdr_count_ff <= hdr_count_in;
         hdr_shift_ff <= hdr_shift_in;
         remaining_ff <= remaining_in;
      end
   end

   assign length = {hdr_shift_ff, data_byte};

   always_comb begin
      phase_in     = phase_ff;
      hdr_count_in = hdr_count_ff;
      hdr_shift_in = hdr_shift_ff;
      remaining_in = remaining_ff;
      step         = '0;
      if (accept) begin
         case (phase_ff)
            lpd_pkg::PH_DISCARD: begin
               // drop bytes until the chunk closes
               if (chunk_end) begin
                  phase_in     = lpd_pkg::PH_HEADER;
                  hdr_count_in = 2'd0;
                  hdr_shift_in = '0;
               end
            end
            lpd_pkg::PH_BODY: begin
               remaining_in                = remaining_ff -
                                             {{(lpd_pkg::LEN_WIDTH-1){1'b0}}, 1'b1};
               step.valid                  = 1'b1;
               step.result.kind            = lpd_pkg::KIND_BODY;
               step.result.body_byte       = data_byte;
               if (remaining_ff == {{(lpd_pkg::LEN_WIDTH-1){1'b0}}, 1'b1}) begin
                  step.result.frame_last = 1'b1;
                  phase_in               = lpd_pkg::PH_HEADER;
                  hdr_count_in           = 2'd0;
                  hdr_shift_in           = '0;
               end
            end
            default: begin
               if (hdr_count_ff != lpd_pkg::HDR_LAST_INDEX) begin
                  hdr_shift_in = {hdr_shift_ff[lpd_pkg::SHIFT_WIDTH-lpd_pkg::BYTE_WIDTH-1:0],
                                  data_byte};
                  hdr_count_in = hdr_count_ff + 2'd1;
                  phase_in     = lpd_pkg::PH_HEADER;
               end else begin
                  hdr_count_in = 2'd0;
                  hdr_shift_in = '0;
                  phase_in     = lpd_pkg::PH_HEADER;
                  if ((length == '0) || (length > max_body_length)) begin
                     step.valid             = 1'b1;
                     step.result.kind       = lpd_pkg::KIND_ERROR;
                     step.result.bad_length = length;
                     if (!chunk_end) begin
                        phase_in = lpd_pkg::PH_DISCARD;
                     end
                  end else begin
                     remaining_in = length;
                     phase_in     = lpd_pkg::PH_BODY;
                  end
               end
            end
         endcase
      end
   end

endmodule

### rtl/length_prefix_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer_core
// Splits a byte stream into frames with 4-byte big-endian length headers.
// ----------------------------------------------------------------------------
// Output: a result is registered and appears on rsp in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the parser state and the result register
//   both update in the cycle of acceptance, so req is ready whenever the
//   result register is empty or being drained.
// Reset: synchronous, active high; the parser returns to the header phase,
//   the result register empties and max_body_length returns to 65536.
// ----------------------------------------------------------------------------
module length_prefix_deframer_core (
   input  logic         clock,
   input  logic         reset,
   lpd_req_if.sink      req,
   lpd_rsp_if.source    rsp,
   input  logic         csr_write_enable,
   input  logic [31:0]  csr_write_data
);

   logic [lpd_pkg::LEN_WIDTH-1:0] max_len_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   lpd_pkg::result_type           rsp_data_ff, rsp_data_in;
   lpd_pkg::step_type             step;
   logic                          accept;

   // Configuration register: load on every write; the parser compares
   // against it only when a header completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= lpd_pkg::MAX_BODY_RESET;
      end else if (csr_write_enable) begin
         max_len_ff <= csr_write_data;
      end
   end

   // Take a new byte whenever the result slot is free or drains this cycle.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   lpd_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req.data_byte),
      .chunk_end       (req.chunk_end),
      .max_body_length (max_len_ff),
      .step            (step)
   );

   // Result register: load on a producing byte, clear once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (step.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.kind       = rsp_data_ff.kind;
   assign rsp.body_byte  = rsp_data_ff.body_byte;
   assign rsp.frame_last = rsp_data_ff.frame_last;
   assign rsp.bad_length = rsp_data_ff.bad_length;

endmodule

### test/tb_length_prefix_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_length_prefix_deframer_core
// Self-checking bench for the length-prefix deframer. Drives a byte stream
// of framed and broken traffic under several maximum body lengths, predicts
// every body byte and length error, and compares them with the result items.
// ----------------------------------------------------------------------------
module tb_length_prefix_deframer_core;
   timeunit 1ns;
   timeprecision 1ps;

   // cycles to let the parser settle after the last result, before a write
   localparam int DRAIN_CYCLES   = 4;
   // cycles without any handshake before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;
   // random items per phase of the run
   localparam int PHASE_ITEMS    = 115;

   // -------------------------------------------------------------------------
   // Frame predictor: tracks the parser state and queues the result items
   // that each accepted byte must produce.
   // -------------------------------------------------------------------------
   class frame_scoreboard;
      logic [lpd_pkg::LEN_WIDTH-1:0]   max_len;
      lpd_pkg::phase_type              phase;
      logic [1:0]                      hdr_count;
      logic [lpd_pkg::SHIFT_WIDTH-1:0] hdr_shift;
      logic [lpd_pkg::LEN_WIDTH-1:0]   body_left;
      lpd_pkg::result_type             pending_results[$];
      int                              failures;

      function new();
         max_len   = lpd_pkg::MAX_BODY_RESET;
         body_left = '0;
         failures  = 0;
         restart_header();
      endfunction

      function void restart_header();
         phase     = lpd_pkg::PH_HEADER;
         hdr_count = '0;
         hdr_shift = '0;
      endfunction

      function void set_max(logic [lpd_pkg::LEN_WIDTH-1:0] value);
         max_len = value;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function string describe(lpd_pkg::result_type r);
         return $sformatf("kind=%0d byte=%02h last=%0d len=%08h",
                          r.kind, r.body_byte, r.frame_last, r.bad_length);
      endfunction

      function void note_byte(logic [lpd_pkg::BYTE_WIDTH-1:0] data, logic chunk_end);
         lpd_pkg::result_type           res;
         logic [lpd_pkg::LEN_WIDTH-1:0] len;
         res = '0;
         case (phase)
            lpd_pkg::PH_DISCARD: begin
               if (chunk_end) restart_header();
            end
            lpd_pkg::PH_BODY: begin
               body_left     = body_left - 1;
               res.kind      = lpd_pkg::KIND_BODY;
               res.body_byte = data;
               if (body_left == 0) begin
                  res.frame_last = 1'b1;
                  restart_header();
               end
               pending_results.push_back(res);
            end
            default: begin
               if (hdr_count != lpd_pkg::HDR_LAST_INDEX) begin
                  hdr_shift = {hdr_shift[lpd_pkg::SHIFT_WIDTH-lpd_pkg::BYTE_WIDTH-1:0],
                               data};
                  hdr_count = hdr_count + 2'd1;
               end else begin
                  len = {hdr_shift, data};
                  restart_header();
                  if (len == 0 || len > max_len) begin
                     res.kind       = lpd_pkg::KIND_ERROR;
                     res.bad_length = len;
                     pending_results.push_back(res);
                     if (!chunk_end) phase = lpd_pkg::PH_DISCARD;
                  end else begin
                     body_left = len;
                     phase     = lpd_pkg::PH_BODY;
                  end
               end
            end
         endcase
      endfunction

      function void check_result(lpd_pkg::result_type got);
         lpd_pkg::result_type want;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: unexpected result %s", $realtime, describe(got));
            return;
         end
         want = pending_results.pop_front();
         if (got.kind != want.kind || got.body_byte != want.body_byte ||
             got.frame_last != want.frame_last || got.bad_length != want.bad_length) begin
            failures++;
            if (failures <= 10)
               $display("%0t: mismatch exp %s, got %s",
                        $realtime, describe(want), describe(got));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                          csr_write_enable;
   logic [lpd_pkg::LEN_WIDTH-1:0] csr_write_data;

   lpd_req_if req_ch ();
   lpd_rsp_if rsp_ch ();

   length_prefix_deframer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   frame_scoreboard               board;
   logic [lpd_pkg::LEN_WIDTH-1:0] cur_limit;     // register value as the stimulus sees it
   int                            items_sent;
   int                            quiet_cycles;
   bit                            req_gaps;      // sender may pause between items
   bit                            rsp_stalls;    // receiver may hold off results
   lpd_pkg::result_type           seen;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor: note every accepted byte and check every accepted result at the
   // clock edge, from the values that stood before the edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            board.note_byte(req_ch.data_byte, req_ch.chunk_end);
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.kind       = rsp_ch.kind;
            seen.body_byte  = rsp_ch.body_byte;
            seen.frame_last = rsp_ch.frame_last;
            seen.bad_length = rsp_ch.bad_length;
            board.check_result(seen);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog: give up once the handshakes stop for too long.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver: while stalls are enabled, hold ready low in bursts of random length;
   // after each burst raise ready again before another can start, so a result can always drain.
   // -------------------------------------------------------------------------
   initial begin : receiver
      int stall_left;
      bit was_ready;
      stall_left   = 0;
      was_ready    = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
            was_ready = 1'b0;
         end else if (rsp_stalls && was_ready && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_ch.ready <= 1'b0;
            was_ready = 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            was_ready = 1'b1;
         end
      end
   end

   function automatic logic random_end();
      return $urandom_range(0, 5) == 0;
   endfunction

   // Offer one byte and hold it until the block takes it. Valid stays high
   // on return so back-to-back bytes stream without a bubble.
   task automatic send_byte(input logic [7:0] data, input logic chunk_end);
      if (req_gaps && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= data;
      req_ch.chunk_end <= chunk_end;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Send the 4-byte big-endian length, most significant byte first.
   task automatic send_header(input logic [31:0] len, input logic end_on_last);
      for (int i = 3; i >= 0; i--)
         send_byte(len[8*i +: 8], (i == 0) ? end_on_last : random_end());
   endtask

   task automatic send_good_frame(input logic [31:0] len);
      send_header(len, random_end());
      for (int unsigned j = 0; j < len; j++)
         send_byte(8'($urandom_range(0, 255)), random_end());
   endtask

   // Illegal header, then garbage up to the chunk end unless the header's
   // last byte already closes the chunk.
   task automatic send_bad_frame(input logic [31:0] len);
      logic end_hdr;
      end_hdr = ($urandom_range(0, 2) == 0);
      send_header(len, end_hdr);
      if (!end_hdr) begin
         repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)), 1'b0);
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   function automatic logic [31:0] pick_good_length();
      logic [31:0] top;
      top = (cur_limit < 24) ? cur_limit : 32'd24;
      if (cur_limit <= 64 && $urandom_range(0, 7) == 0) return cur_limit;
      return $urandom_range(1, top);
   endfunction

   function automatic logic [31:0] pick_bad_length();
      logic [31:0] len;
      int          pick;
      pick = $urandom_range(0, 2);
      if (cur_limit == 32'hFFFF_FFFF || pick == 0) return 32'd0;
      if (pick == 1) return cur_limit + 1;
      len = $urandom;
      if (len <= cur_limit) len = cur_limit + 1 + (len % (32'hFFFF_FFFF - cur_limit));
      return len;
   endfunction

   // Write the length limit once every result is out and the parser has
   // settled; the byte channel is held idle around the write.
   task automatic write_max_length(input logic [31:0] value);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_max(value);
      cur_limit = value;
   endtask

   // Mostly well-formed frames with random content, the rest illegal
   // headers followed by dropped garbage; only illegal ones at a zero limit.
   task automatic run_random(input int budget);
      int target;
      target = items_sent + budget;
      while (items_sent < target) begin
         if (cur_limit == 0 || $urandom_range(0, 4) == 0)
            send_bad_frame(pick_bad_length());
         else
            send_good_frame(pick_good_length());
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      board      = new();
      cur_limit  = lpd_pkg::MAX_BODY_RESET;
      items_sent = 0;
      req_gaps   = 1'b1;
      rsp_stalls = 1'b1;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.chunk_end <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: small limit so the boundary lengths are cheap.
      write_max_length(32'd16);
      // one-byte body, closing the chunk
      send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0); send_byte(8'hFF, 1'b1);
      // zero length: error, then drop up to the chunk end
      send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0); send_byte(8'hAA, 1'b0); send_byte(8'h55, 1'b1);
      // all-ones length with the chunk ending on the header: nothing dropped
      send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      // chunk ends inside the header and inside the body have no effect
      send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b1); send_byte(8'h00, 1'b0);
      send_byte(8'h02, 1'b0); send_byte(8'h00, 1'b1); send_byte(8'h80, 1'b0);
      // one above the limit, chunk closing on the header
      send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
      send_byte(8'h11, 1'b1);

      write_max_length(lpd_pkg::MAX_BODY_RESET);
      run_random(PHASE_ITEMS);

      req_gaps = 1'b1; rsp_stalls = 1'b0;
      write_max_length(32'd1);
      run_random(PHASE_ITEMS);

      // Leave a header half done, then drop the limit to zero: the new
      // value applies when that header completes.
      req_gaps = 1'b0; rsp_stalls = 1'b1;
      send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
      write_max_length(32'd0);
      send_byte(8'h00, 1'b0); send_byte(8'h05, 1'b1);
      run_random(PHASE_ITEMS);

      req_gaps = 1'b1; rsp_stalls = 1'b1;
      write_max_length(32'hFFFF_FFFF);
      run_random(PHASE_ITEMS);

      write_max_length($urandom_range(2, 40));
      run_random(PHASE_ITEMS);

      // Last stretch at full rate on both sides.
      req_gaps = 1'b0; rsp_stalls = 1'b0;
      write_max_length($urandom_range(8, 24));
      run_random(PHASE_ITEMS);

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.failures == 0 && board.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### filelist.f
rtl/lpd_pkg.sv
rtl/lpd_req_if.sv
rtl/lpd_rsp_if.sv
rtl/lpd_parser.sv
rtl/length_prefix_deframer_core.sv
test/tb_length_prefix_deframer_core.sv
